@@ rtl/core/sfpm_pkg.sv @@
// Package for the skin and foreground pixel mask block.
// Holds the register map, reset values, fixed-point coefficients and the config struct.
// No dependencies.
package sfpm_pkg;

  localparam int unsigned RegIdxW = 3;

  localparam logic [RegIdxW-1:0] REG_FG_THRESHOLD = 3'd0;
  localparam logic [RegIdxW-1:0] REG_LUMA_LOW     = 3'd1;
  localparam logic [RegIdxW-1:0] REG_LUMA_HIGH    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_CR_LOW       = 3'd3;
  localparam logic [RegIdxW-1:0] REG_CR_HIGH      = 3'd4;
  localparam logic [RegIdxW-1:0] REG_CB_LOW       = 3'd5;
  localparam logic [RegIdxW-1:0] REG_CB_HIGH      = 3'd6;

  localparam logic [7:0] RST_FG_THRESHOLD = 8'd30;
  localparam logic [7:0] RST_LUMA_LOW     = 8'd0;
  localparam logic [7:0] RST_LUMA_HIGH    = 8'd255;
  localparam logic [7:0] RST_CR_LOW       = 8'd136;
  localparam logic [7:0] RST_CR_HIGH      = 8'd180;
  localparam logic [7:0] RST_CB_LOW       = 8'd85;
  localparam logic [7:0] RST_CB_HIGH      = 8'd135;

  // BT.601 coefficients in Q14
  localparam logic [21:0] COEF_RY = 22'd4899;
  localparam logic [21:0] COEF_GY = 22'd9617;
  localparam logic [21:0] COEF_BY = 22'd1868;
  localparam logic [21:0] Q_HALF  = 22'd8192;
  localparam logic [23:0] COEF_CR = 24'd11682;
  localparam logic [23:0] COEF_CB = 24'd9241;
  // (128 + 256) << 14 plus rounding half
  localparam logic [23:0] CHROMA_BIAS = 24'd6299648;

  typedef struct packed {
    logic [7:0] fg_threshold;
    logic [7:0] luma_low;
    logic [7:0] luma_high;
    logic [7:0] cr_low;
    logic [7:0] cr_high;
    logic [7:0] cb_low;
    logic [7:0] cb_high;
  } cfg_t;

endpackage

@@ rtl/core/sfpm_cfg.sv @@
// Configuration register bank for the skin and foreground pixel mask block.
// Depends on sfpm_pkg.
module sfpm_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wen,
  input  logic [sfpm_pkg::RegIdxW-1:0]   cfg_index,
  input  logic [7:0]                     cfg_wdata,
  output sfpm_pkg::cfg_t                 cfg
);

  sfpm_pkg::cfg_t cfg_r;
  sfpm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wen) begin
      case (cfg_index)
        sfpm_pkg::REG_FG_THRESHOLD: cfg_nxt.fg_threshold = cfg_wdata;
        sfpm_pkg::REG_LUMA_LOW:     cfg_nxt.luma_low     = cfg_wdata;
        sfpm_pkg::REG_LUMA_HIGH:    cfg_nxt.luma_high    = cfg_wdata;
        sfpm_pkg::REG_CR_LOW:       cfg_nxt.cr_low       = cfg_wdata;
        sfpm_pkg::REG_CR_HIGH:      cfg_nxt.cr_high      = cfg_wdata;
        sfpm_pkg::REG_CB_LOW:       cfg_nxt.cb_low       = cfg_wdata;
        sfpm_pkg::REG_CB_HIGH:      cfg_nxt.cb_high      = cfg_wdata;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg_threshold <= sfpm_pkg::RST_FG_THRESHOLD;
      cfg_r.luma_low     <= sfpm_pkg::RST_LUMA_LOW;
      cfg_r.luma_high    <= sfpm_pkg::RST_LUMA_HIGH;
      cfg_r.cr_low       <= sfpm_pkg::RST_CR_LOW;
      cfg_r.cr_high      <= sfpm_pkg::RST_CR_HIGH;
      cfg_r.cb_low       <= sfpm_pkg::RST_CB_LOW;
      cfg_r.cb_high      <= sfpm_pkg::RST_CB_HIGH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/sfpm_fg.sv @@
// Foreground datapath: absolute differences, squares, distance compare over three stages.
// Depends on sfpm_pkg.
module sfpm_fg (
  input  logic            clk,
  input  logic            adv,
  input  logic [7:0]      cur_blue,
  input  logic [7:0]      cur_green,
  input  logic [7:0]      cur_red,
  input  logic [7:0]      bg_blue,
  input  logic [7:0]      bg_green,
  input  logic [7:0]      bg_red,
  input  sfpm_pkg::cfg_t  cfg,
  output logic            fg
);

  logic [7:0]  db_r, dg_r, dr_r;
  logic [7:0]  db_nxt, dg_nxt, dr_nxt;
  logic [15:0] sb_r, sg_r, sr_r, tt_r;
  logic [15:0] sb_nxt, sg_nxt, sr_nxt, tt_nxt;
  logic [17:0] sq_sum;
  logic        fg_r;
  logic        fg_nxt;

  assign db_nxt = (bg_blue  > cur_blue)  ? bg_blue  - cur_blue  : cur_blue  - bg_blue;
  assign dg_nxt = (bg_green > cur_green) ? bg_green - cur_green : cur_green - bg_green;
  assign dr_nxt = (bg_red   > cur_red)   ? bg_red   - cur_red   : cur_red   - bg_red;

  assign sb_nxt = 16'(db_r) * 16'(db_r);
  assign sg_nxt = 16'(dg_r) * 16'(dg_r);
  assign sr_nxt = 16'(dr_r) * 16'(dr_r);
  assign tt_nxt = 16'(cfg.fg_threshold) * 16'(cfg.fg_threshold);

  assign sq_sum = 18'(sb_r) + 18'(sg_r) + 18'(sr_r);
  assign fg_nxt = sq_sum > 18'(tt_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      db_r <= db_nxt;
      dg_r <= dg_nxt;
      dr_r <= dr_nxt;
      sb_r <= sb_nxt;
      sg_r <= sg_nxt;
      sr_r <= sr_nxt;
      tt_r <= tt_nxt;
      fg_r <= fg_nxt;
    end
  end

  assign fg = fg_r;

endmodule

@@ rtl/core/sfpm_color.sv @@
// Colour datapath: BT.601 luma and chroma in Q14 over three stages, then range tests.
// Depends on sfpm_pkg.
module sfpm_color (
  input  logic            clk,
  input  logic            adv,
  input  logic [7:0]      cur_blue,
  input  logic [7:0]      cur_green,
  input  logic [7:0]      cur_red,
  input  sfpm_pkg::cfg_t  cfg,
  output logic            range_ok
);

  // stage A: luma products
  logic [21:0] py_r, pg_r, pb_r;
  logic [21:0] py_nxt, pg_nxt, pb_nxt;
  logic [7:0]  ra_r, ba_r;
  // stage B: luma
  logic [21:0] ysum;
  logic [7:0]  yb_r, rb_r, bb_r;
  // stage C: chroma products
  logic signed [8:0]  dcr, dcb;
  logic signed [23:0] dcr_ext, dcb_ext, coef_cr_s, coef_cb_s;
  logic signed [23:0] pcr_r, pcb_r, pcr_nxt, pcb_nxt;
  logic [7:0]  yc_r;
  // range tests
  logic [23:0] acc_cr, acc_cb;
  logic [9:0]  sh_cr, sh_cb;
  logic [7:0]  cr_val, cb_val;
  logic        y_ok, cr_ok, cb_ok;

  assign py_nxt = 22'(cur_red)   * sfpm_pkg::COEF_RY;
  assign pg_nxt = 22'(cur_green) * sfpm_pkg::COEF_GY;
  assign pb_nxt = 22'(cur_blue)  * sfpm_pkg::COEF_BY;

  assign ysum = py_r + pg_r + pb_r + sfpm_pkg::Q_HALF;

  assign dcr       = $signed({1'b0, rb_r}) - $signed({1'b0, yb_r});
  assign dcb       = $signed({1'b0, bb_r}) - $signed({1'b0, yb_r});
  assign dcr_ext   = 24'(dcr);
  assign dcb_ext   = 24'(dcb);
  assign coef_cr_s = $signed(sfpm_pkg::COEF_CR);
  assign coef_cb_s = $signed(sfpm_pkg::COEF_CB);
  assign pcr_nxt   = dcr_ext * coef_cr_s;
  assign pcb_nxt   = dcb_ext * coef_cb_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      py_r  <= py_nxt;
      pg_r  <= pg_nxt;
      pb_r  <= pb_nxt;
      ra_r  <= cur_red;
      ba_r  <= cur_blue;
      yb_r  <= ysum[21:14];
      rb_r  <= ra_r;
      bb_r  <= ba_r;
      pcr_r <= pcr_nxt;
      pcb_r <= pcb_nxt;
      yc_r  <= yb_r;
    end
  end

  // biased sum is always positive; shifted value lies in 202..566 before the clamp below
  assign acc_cr = $unsigned(pcr_r) + sfpm_pkg::CHROMA_BIAS;
  assign acc_cb = $unsigned(pcb_r) + sfpm_pkg::CHROMA_BIAS;
  assign sh_cr  = acc_cr[23:14];
  assign sh_cb  = acc_cb[23:14];

  always_comb begin
    if (sh_cr[9]) begin
      cr_val = 8'd255;
    end else if (!sh_cr[8]) begin
      cr_val = 8'd0;
    end else begin
      cr_val = sh_cr[7:0];
    end
    if (sh_cb[9]) begin
      cb_val = 8'd255;
    end else if (!sh_cb[8]) begin
      cb_val = 8'd0;
    end else begin
      cb_val = sh_cb[7:0];
    end
  end

  assign y_ok  = (yc_r   >= cfg.luma_low) && (yc_r   <= cfg.luma_high);
  assign cr_ok = (cr_val >= cfg.cr_low)   && (cr_val <= cfg.cr_high);
  assign cb_ok = (cb_val >= cfg.cb_low)   && (cb_val <= cfg.cb_high);

  assign range_ok = y_ok && cr_ok && cb_ok;

endmodule

@@ rtl/core/skin_foreground_pixel_mask.sv @@
// Top level of the skin and foreground pixel mask block.
// Depends on sfpm_pkg, sfpm_cfg, sfpm_fg and sfpm_color.
//
//   channel  | ports                                       | direction
//   in       | in_valid, in_stall, in_cur_*, in_bg_*        | pixel word in
//   out      | out_valid, out_stall, out_skin_mask, out_foreground | result word out
//   cfg      | cfg_wen, cfg_index, cfg_wdata                | register write
//
// One word per cycle unless a stalled output word holds the pipe.
// Three datapath stages plus the output register; valid bits follow each stage.
// A stalled output word freezes the whole pipe and raises in_stall; nothing drops.
// Synchronous reset clears valid bits and loads register defaults.
module skin_foreground_pixel_mask (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_cur_blue,
  input  logic [7:0]                    in_cur_green,
  input  logic [7:0]                    in_cur_red,
  input  logic [7:0]                    in_bg_blue,
  input  logic [7:0]                    in_bg_green,
  input  logic [7:0]                    in_bg_red,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_skin_mask,
  output logic                          out_foreground,
  input  logic                          cfg_wen,
  input  logic [sfpm_pkg::RegIdxW-1:0]  cfg_index,
  input  logic [7:0]                    cfg_wdata
);

  sfpm_pkg::cfg_t cfg;
  logic adv;
  logic va_r, vb_r, vc_r, vo_r;
  logic va_nxt;
  logic fg_c, range_ok;
  logic skin_r, fgo_r;

  sfpm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sfpm_fg u_fg (
    .clk       (clk),
    .adv       (adv),
    .cur_blue  (in_cur_blue),
    .cur_green (in_cur_green),
    .cur_red   (in_cur_red),
    .bg_blue   (in_bg_blue),
    .bg_green  (in_bg_green),
    .bg_red    (in_bg_red),
    .cfg       (cfg),
    .fg        (fg_c)
  );

  sfpm_color u_color (
    .clk       (clk),
    .adv       (adv),
    .cur_blue  (in_cur_blue),
    .cur_green (in_cur_green),
    .cur_red   (in_cur_red),
    .cfg       (cfg),
    .range_ok  (range_ok)
  );

  assign adv      = !(vo_r && out_stall);
  assign in_stall = !adv;
  assign va_nxt   = in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      va_r <= va_nxt;
      vb_r <= va_r;
      vc_r <= vb_r;
      vo_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      skin_r <= fg_c && range_ok;
      fgo_r  <= fg_c;
    end
  end

  assign out_valid      = vo_r;
  assign out_skin_mask  = skin_r;
  assign out_foreground = fgo_r;

endmodule

@@ test/sfpm_mask_checker.sv @@
// Checker for the skin and foreground pixel mask block: tracks register writes,
// predicts both mask bits per accepted pixel word and compares result words in order.
// Depends on sfpm_pkg for the register map, reset values and the config struct.
module sfpm_mask_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [7:0]                    in_cur_blue,
  input  logic [7:0]                    in_cur_green,
  input  logic [7:0]                    in_cur_red,
  input  logic [7:0]                    in_bg_blue,
  input  logic [7:0]                    in_bg_green,
  input  logic [7:0]                    in_bg_red,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_skin_mask,
  input  logic                          out_foreground,
  input  logic                          cfg_wen,
  input  logic [sfpm_pkg::RegIdxW-1:0]  cfg_index,
  input  logic [7:0]                    cfg_wdata,
  output int                            mismatches,
  output int                            pending
);

  localparam int LumaR      = 4899;
  localparam int LumaG      = 9617;
  localparam int LumaB      = 1868;
  localparam int CrGain     = 11682;
  localparam int CbGain     = 9241;
  localparam int FracBits   = 14;
  localparam int HalfLsb    = 1 << (FracBits - 1);
  localparam int ChromaMid  = 128;
  localparam int FloorBias  = 256;

  typedef struct packed {
    logic skin;
    logic fg;
  } mask_word_t;

  sfpm_pkg::cfg_t regs_now;
  mask_word_t     expected_masks[$];
  mask_word_t     want;
  int             result_no;

  function automatic logic [7:0] chroma_of(int diff, int gain);
    int acc;
    int v;
    acc = diff * gain + ((ChromaMid + FloorBias) << FracBits) + HalfLsb;
    if (acc < 0) acc = 0;
    v = (acc >> FracBits) - FloorBias;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic int sq_diff(logic [7:0] a, logic [7:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  function automatic mask_word_t classify_pixel(sfpm_pkg::cfg_t c, logic [7:0] blue,
                                                logic [7:0] green,
                                                logic [7:0] red, logic [7:0] bg_b,
                                                logic [7:0] bg_g, logic [7:0] bg_r);
    int         sq_sum;
    int         thr;
    int         y;
    logic [7:0] luma;
    logic [7:0] cr_v;
    logic [7:0] cb_v;
    mask_word_t m;
    sq_sum = sq_diff(blue, bg_b) + sq_diff(green, bg_g) + sq_diff(red, bg_r);
    thr = int'(c.fg_threshold);
    m.fg = sq_sum > thr * thr;
    y = (LumaR * int'(red) + LumaG * int'(green) + LumaB * int'(blue) + HalfLsb) >> FracBits;
    if (y > 255) y = 255;
    luma = y[7:0];
    cr_v = chroma_of(int'(red) - y, CrGain);
    cb_v = chroma_of(int'(blue) - y, CbGain);
    m.skin = m.fg && luma >= c.luma_low && luma <= c.luma_high
             && cr_v >= c.cr_low && cr_v <= c.cr_high
             && cb_v >= c.cb_low && cb_v <= c.cb_high;
    return m;
  endfunction

  task automatic report_fault(string msg);
    $display("mask check: %s", msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs_now = {sfpm_pkg::RST_FG_THRESHOLD, sfpm_pkg::RST_LUMA_LOW,
                  sfpm_pkg::RST_LUMA_HIGH, sfpm_pkg::RST_CR_LOW, sfpm_pkg::RST_CR_HIGH,
                  sfpm_pkg::RST_CB_LOW, sfpm_pkg::RST_CB_HIGH};
      expected_masks.delete();
      result_no = 0;
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_masks.size() == 0) begin
          report_fault($sformatf("result word %0d with nothing expected", result_no));
        end else begin
          want = expected_masks.pop_front();
          if (out_skin_mask !== want.skin)
            report_fault($sformatf("word %0d skin_mask got %b want %b",
                                   result_no, out_skin_mask, want.skin));
          if (out_foreground !== want.fg)
            report_fault($sformatf("word %0d foreground got %b want %b",
                                   result_no, out_foreground, want.fg));
        end
        result_no++;
      end
      if (in_valid && !in_stall)
        expected_masks.insert(expected_masks.size(),
                              classify_pixel(regs_now, in_cur_blue, in_cur_green,
                                             in_cur_red, in_bg_blue, in_bg_green,
                                             in_bg_red));
      if (cfg_wen) begin
        case (cfg_index)
          sfpm_pkg::REG_FG_THRESHOLD: regs_now.fg_threshold = cfg_wdata;
          sfpm_pkg::REG_LUMA_LOW:     regs_now.luma_low = cfg_wdata;
          sfpm_pkg::REG_LUMA_HIGH:    regs_now.luma_high = cfg_wdata;
          sfpm_pkg::REG_CR_LOW:       regs_now.cr_low = cfg_wdata;
          sfpm_pkg::REG_CR_HIGH:      regs_now.cr_high = cfg_wdata;
          sfpm_pkg::REG_CB_LOW:       regs_now.cb_low = cfg_wdata;
          sfpm_pkg::REG_CB_HIGH:      regs_now.cb_high = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = expected_masks.size();
  end

endmodule

@@ test/tb_skin_foreground_pixel_mask.sv @@
// Testbench top for the skin and foreground pixel mask block: resets it, drives
// directed and random pixel words through several register settings with random idling.
// Depends on sfpm_pkg, skin_foreground_pixel_mask and sfpm_mask_checker.
module tb_skin_foreground_pixel_mask;

  localparam logic [sfpm_pkg::RegIdxW-1:0] REG_SPARE = 3'd7;
  localparam int NumPhases   = 8;
  localparam int PhaseWords  = 125;
  localparam int HoldPhase   = 1;
  localparam int HoldCycles  = 90;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 600000;

  typedef struct packed {
    logic [7:0] cur_blue;
    logic [7:0] cur_green;
    logic [7:0] cur_red;
    logic [7:0] bg_blue;
    logic [7:0] bg_green;
    logic [7:0] bg_red;
  } pixel_word_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [7:0]                   in_cur_blue;
  logic [7:0]                   in_cur_green;
  logic [7:0]                   in_cur_red;
  logic [7:0]                   in_bg_blue;
  logic [7:0]                   in_bg_green;
  logic [7:0]                   in_bg_red;
  logic                         out_valid;
  logic                         out_stall;
  logic                         out_skin_mask;
  logic                         out_foreground;
  logic                         cfg_wen;
  logic [sfpm_pkg::RegIdxW-1:0] cfg_index;
  logic [7:0]                   cfg_wdata;
  int                           mismatch_count;
  int                           masks_pending;
  int                           cycle_count = 0;
  bit                           hold_req = 1'b0;

  always #5 clk = ~clk;

  skin_foreground_pixel_mask dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cur_blue    (in_cur_blue),
    .in_cur_green   (in_cur_green),
    .in_cur_red     (in_cur_red),
    .in_bg_blue     (in_bg_blue),
    .in_bg_green    (in_bg_green),
    .in_bg_red      (in_bg_red),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_skin_mask  (out_skin_mask),
    .out_foreground (out_foreground),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  sfpm_mask_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cur_blue    (in_cur_blue),
    .in_cur_green   (in_cur_green),
    .in_cur_red     (in_cur_red),
    .in_bg_blue     (in_bg_blue),
    .in_bg_green    (in_bg_green),
    .in_bg_red      (in_bg_red),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_skin_mask  (out_skin_mask),
    .out_foreground (out_foreground),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatch_count),
    .pending        (masks_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[skin_foreground_pixel_mask] ERROR");
      $finish;
    end
  end

  // result side: alternate stall and free runs, hold off on request
  initial begin : receiver
    int  run_left;
    bit  level;
    int  r;
    run_left = 0;
    level = 1'b1;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
        run_left = 0;
        level = 1'b1;
      end
      if (run_left == 0) begin
        level = !level;
        r = $urandom_range(0, 99);
        if (level)
          run_left = (r < 85) ? $urandom_range(1, 3) : $urandom_range(12, 40);
        else
          run_left = (r < 70) ? $urandom_range(1, 6) : $urandom_range(30, 120);
      end
      out_stall <= level;
      run_left--;
    end
  end

  function automatic pixel_word_t make_pixel(logic [7:0] cb, logic [7:0] cg, logic [7:0] cr,
                                             logic [7:0] bb, logic [7:0] bgg, logic [7:0] br);
    pixel_word_t p;
    p.cur_blue = cb;
    p.cur_green = cg;
    p.cur_red = cr;
    p.bg_blue = bb;
    p.bg_green = bgg;
    p.bg_red = br;
    return p;
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] v, int span);
    int off;
    int t;
    off = $urandom_range(0, 2 * span);
    t = int'(v) + off - span;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  function automatic pixel_word_t random_pixel();
    pixel_word_t p;
    int kind;
    kind = $urandom_range(0, 9);
    p = make_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    if (kind >= 3 && kind < 6) begin
      p.cur_red = 8'($urandom_range(120, 255));
      p.cur_green = 8'($urandom_range(60, 200));
      p.cur_blue = 8'($urandom_range(40, 180));
    end
    if (kind >= 4 && kind < 9) begin
      p.bg_blue = nudge(p.cur_blue, 40);
      p.bg_green = nudge(p.cur_green, 40);
      p.bg_red = nudge(p.cur_red, 40);
    end else if (kind == 9) begin
      p.bg_blue = p.cur_blue;
      p.bg_green = p.cur_green;
      p.bg_red = p.cur_red;
    end
    return p;
  endfunction

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 45);
  endfunction

  function automatic logic [15:0] random_bounds();
    logic [7:0] lo;
    lo = 8'($urandom_range(0, 255));
    return {lo, 8'($urandom_range(lo, 255))};
  endfunction

  function automatic sfpm_pkg::cfg_t phase_settings(int ph);
    sfpm_pkg::cfg_t c;
    logic [63:0]    raw;
    case (ph)
      0: c = {sfpm_pkg::RST_FG_THRESHOLD, sfpm_pkg::RST_LUMA_LOW, sfpm_pkg::RST_LUMA_HIGH,
              sfpm_pkg::RST_CR_LOW, sfpm_pkg::RST_CR_HIGH, sfpm_pkg::RST_CB_LOW,
              sfpm_pkg::RST_CB_HIGH};
      1: c = {8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
      2: c = {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
      3: c = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
      4: c = {8'd12, 8'd200, 8'd100, 8'd180, 8'd136, 8'd135, 8'd85};
      5: c = {8'd20, 8'd60, 8'd230, 8'd140, 8'd175, 8'd90, 8'd130};
      6: c = {8'($urandom_range(0, 255)), random_bounds(), random_bounds(), random_bounds()};
      default: begin
        raw = {$urandom, $urandom};
        c = raw[55:0];
      end
    endcase
    return c;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_pixel(pixel_word_t p, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cur_blue <= p.cur_blue;
    in_cur_green <= p.cur_green;
    in_cur_red <= p.cur_red;
    in_bg_blue <= p.bg_blue;
    in_bg_green <= p.bg_green;
    in_bg_red <= p.bg_red;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [sfpm_pkg::RegIdxW-1:0] idx, logic [7:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic program_regs(sfpm_pkg::cfg_t c);
    write_reg(sfpm_pkg::REG_FG_THRESHOLD, c.fg_threshold);
    write_reg(sfpm_pkg::REG_LUMA_LOW, c.luma_low);
    write_reg(sfpm_pkg::REG_LUMA_HIGH, c.luma_high);
    write_reg(sfpm_pkg::REG_CR_LOW, c.cr_low);
    write_reg(sfpm_pkg::REG_CR_HIGH, c.cr_high);
    write_reg(sfpm_pkg::REG_CB_LOW, c.cb_low);
    write_reg(sfpm_pkg::REG_CB_HIGH, c.cb_high);
    write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
    cfg_wen <= 1'b0;
  endtask

  // drop valid, drain the pipe, then let it go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (masks_pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  initial begin : stimulus
    int ph;
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cur_blue = 8'd0;
    in_cur_green = 8'd0;
    in_cur_red = 8'd0;
    in_bg_blue = 8'd0;
    in_bg_green = 8'd0;
    in_bg_red = 8'd0;
    cfg_wen = 1'b0;
    cfg_index = '0;
    cfg_wdata = 8'd0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 0);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0), 0);
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255), 1);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255), 0);
    send_pixel(make_pixel(8'd30, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 0);
    send_pixel(make_pixel(8'd30, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0), 2);
    send_pixel(make_pixel(8'd110, 8'd140, 8'd200, 8'd0, 8'd0, 8'd0), 0);
    send_pixel(make_pixel(8'd110, 8'd140, 8'd200, 8'd110, 8'd140, 8'd200), 0);
    send_pixel(make_pixel(8'd110, 8'd140, 8'd200, 8'd90, 8'd140, 8'd200), 0);
    send_pixel(make_pixel(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0), 3);
    send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 0);
    send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0), 0);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0), 0);
    send_pixel(make_pixel(8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0), 1);
    send_pixel(make_pixel(8'd128, 8'd128, 8'd128, 8'd0, 8'd0, 8'd0), 0);
    send_pixel(make_pixel(8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55), 0);
    send_pixel(make_pixel(8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa), 0);
    send_pixel(make_pixel(8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0), 0);

    for (ph = 0; ph < NumPhases; ph++) begin
      settle();
      program_regs(phase_settings(ph));
      if (ph == HoldPhase) hold_req = 1'b1;
      for (n = 0; n < PhaseWords; n++)
        send_pixel(random_pixel(), pick_gap(ph % 2 == 1));
    end

    settle();
    if (mismatch_count == 0)
      $display("[skin_foreground_pixel_mask] OK");
    else
      $display("[skin_foreground_pixel_mask] ERROR");
    $finish;
  end

endmodule
